// ===== hdl/agc_gain_state_stepper_core_defines.svh =====
// Assertion macros shared by the AGC gain state stepper RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef AGC_GAIN_STATE_STEPPER_CORE_DEFINES_SVH
`define AGC_GAIN_STATE_STEPPER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define AGC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define AGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AGC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define AGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/agcgss_pkg.sv =====
// Types and constants for the AGC gain state stepper.
// No dependencies; used by every module of the block.
package agcgss_pkg;

  localparam int NUM_STATES = 2;
  localparam int STATE_W    = $clog2(NUM_STATES);
  localparam int TICK_W     = 32;
  localparam int LEVEL_W    = 15;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [STATE_W-1:0] STATE_ACTIVE = STATE_W'(0);
  localparam logic [STATE_W-1:0] STATE_LAST   = STATE_W'(NUM_STATES - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ACTIVE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ACTIVE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_QUIET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_QUIET   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_QUIET  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 3'd6;

  // reset values
  localparam logic [GAIN_W-1:0]  RST_GAIN_ACTIVE = 16'd0;
  localparam logic [LEVEL_W-1:0] RST_LOW_ACTIVE  = 15'd350;
  localparam logic [LEVEL_W-1:0] RST_HIGH_ACTIVE = 15'd30000;
  localparam logic [GAIN_W-1:0]  RST_GAIN_QUIET  = 16'd0;
  localparam logic [LEVEL_W-1:0] RST_LOW_QUIET   = 15'd0;
  localparam logic [LEVEL_W-1:0] RST_HIGH_QUIET  = 15'd400;
  localparam logic [TICK_W-1:0]  RST_HOLD_TICKS  = 32'd2000;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [TICK_W-1:0]  tick_now;
  } in_item_t;

  typedef struct packed {
    logic               gain_changed;
    logic [GAIN_W-1:0]  gain_value;
    logic [STATE_W-1:0] state_index;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_active;
    logic [LEVEL_W-1:0] low_active;
    logic [LEVEL_W-1:0] high_active;
    logic [GAIN_W-1:0]  gain_quiet;
    logic [LEVEL_W-1:0] low_quiet;
    logic [LEVEL_W-1:0] high_quiet;
    logic [TICK_W-1:0]  hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [STATE_W-1:0] gain_state;
    logic [TICK_W-1:0]  below_time;
    logic [TICK_W-1:0]  last_stamp;
  } agc_state_t;

endpackage

// ===== hdl/agc_gain_state_stepper_core.sv =====
// Top level of the AGC gain state stepper: input register, step logic, result register.
// Depends on agcgss_pkg, agcgss_cfg_regs, agcgss_step and the defines header.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | in_data  (level, tick_now)
//   out_    | output    | out_valid/out_ready  | out_data (gain_changed, gain_value, state_index)
//   cfg_    | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One transaction per cycle while out_ready does not stall; a taken input is held in the
// input register, then the step logic updates state and loads the result register.
// State feeds back from the state register through the 32-bit subtract, add and compare.
// Reset clears state to the active gain state with unset timers and loads register defaults.
// A stall on out_ready holds the result register; an empty input register still takes one more.
`include "agc_gain_state_stepper_core_defines.svh"

module agc_gain_state_stepper_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  agcgss_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output agcgss_pkg::out_item_t             out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [agcgss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [agcgss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import agcgss_pkg::*;

  cfg_t       cfg;
  agc_state_t state_r;
  agc_state_t state_nxt;
  in_item_t   s1_item_r;
  logic       s1_valid_r;
  out_item_t  res;
  out_item_t  out_r;
  logic       out_valid_r;
  logic       out_adv;
  logic       upd;
  logic       timers_clear;
  logic       gain_ok;

  assign cfg_ready = 1'b1;

  agcgss_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  agcgss_step u_step (
    .item (s1_item_r),
    .cfg  (cfg),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res)
  );

  assign out_adv  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_adv;
  assign upd      = s1_valid_r && out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (upd) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (upd) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign timers_clear = (state_r.below_time == '0) && (state_r.last_stamp == '0);
  assign gain_ok      = out_data.gain_value ==
                        ((out_data.state_index == STATE_ACTIVE) ? cfg.gain_active
                                                                : cfg.gain_quiet);

  // result reports the state that the update leaves behind
  `AGC_ASSERT_NEXT(a_state_matches, clk, rst_n, upd, out_data.state_index == state_r.gain_state)
  // every switch clears both timers
  `AGC_ASSERT_NEXT(a_switch_clears, clk, rst_n, upd && res.gain_changed, timers_clear)
  // delivered gain belongs to the reported state
  `AGC_ASSERT_IMPL(a_gain_of_state, clk, rst_n, out_valid && out_ready, gain_ok)

endmodule

// ===== hdl/agcgss_cfg_regs.sv =====
// Configuration register file of the AGC gain state stepper.
// Depends on agcgss_pkg.
module agcgss_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [agcgss_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [agcgss_pkg::CFG_DATA_W-1:0]   wr_data,
  output agcgss_pkg::cfg_t                    cfg
);
  import agcgss_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_GAIN_ACTIVE: cfg_nxt.gain_active = wr_data[GAIN_W-1:0];
        REG_LOW_ACTIVE:  cfg_nxt.low_active  = wr_data[LEVEL_W-1:0];
        REG_HIGH_ACTIVE: cfg_nxt.high_active = wr_data[LEVEL_W-1:0];
        REG_GAIN_QUIET:  cfg_nxt.gain_quiet  = wr_data[GAIN_W-1:0];
        REG_LOW_QUIET:   cfg_nxt.low_quiet   = wr_data[LEVEL_W-1:0];
        REG_HIGH_QUIET:  cfg_nxt.high_quiet  = wr_data[LEVEL_W-1:0];
        REG_HOLD_TICKS:  cfg_nxt.hold_ticks  = wr_data[TICK_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_active <= RST_GAIN_ACTIVE;
      cfg_r.low_active  <= RST_LOW_ACTIVE;
      cfg_r.high_active <= RST_HIGH_ACTIVE;
      cfg_r.gain_quiet  <= RST_GAIN_QUIET;
      cfg_r.low_quiet   <= RST_LOW_QUIET;
      cfg_r.high_quiet  <= RST_HIGH_QUIET;
      cfg_r.hold_ticks  <= RST_HOLD_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/agcgss_step.sv =====
// Next-state and result logic for one level measurement.
// Depends on agcgss_pkg.
module agcgss_step (
  input  agcgss_pkg::in_item_t   item,
  input  agcgss_pkg::cfg_t       cfg,
  input  agcgss_pkg::agc_state_t cur,
  output agcgss_pkg::agc_state_t nxt,
  output agcgss_pkg::out_item_t  res
);
  import agcgss_pkg::*;

  logic [LEVEL_W-1:0] lo;
  logic [LEVEL_W-1:0] hi;
  logic               below;
  logic               above;
  logic [TICK_W-1:0]  dt;
  logic [TICK_W:0]    sum;
  logic [TICK_W-1:0]  acc;
  logic               hold_hit;
  logic               changed;

  always_comb begin
    lo = (cur.gain_state == STATE_ACTIVE) ? cfg.low_active  : cfg.low_quiet;
    hi = (cur.gain_state == STATE_ACTIVE) ? cfg.high_active : cfg.high_quiet;
    below = item.level < lo;
    above = item.level > hi;

    // elapsed time wraps with the tick counter; accumulator saturates
    dt       = item.tick_now - cur.last_stamp;
    sum      = {1'b0, cur.below_time} + {1'b0, dt};
    acc      = sum[TICK_W] ? {TICK_W{1'b1}} : sum[TICK_W-1:0];
    hold_hit = acc >= cfg.hold_ticks;

    nxt     = cur;
    changed = 1'b0;
    if (below) begin
      if (cur.last_stamp == '0) begin
        nxt.last_stamp = item.tick_now;
      end else if (hold_hit) begin
        if (cur.gain_state != STATE_LAST) begin
          nxt.gain_state = cur.gain_state + STATE_W'(1);
        end
        nxt.below_time = '0;
        nxt.last_stamp = '0;
        changed        = 1'b1;
      end else begin
        nxt.below_time = acc;
        nxt.last_stamp = item.tick_now;
      end
    end else if (above) begin
      if (cur.gain_state != STATE_ACTIVE) begin
        nxt.gain_state = STATE_ACTIVE;
        nxt.below_time = '0;
        nxt.last_stamp = '0;
        changed        = 1'b1;
      end
    end else begin
      nxt.below_time = '0;
      nxt.last_stamp = '0;
    end

    res.gain_changed = changed;
    res.gain_value   = (nxt.gain_state == STATE_ACTIVE) ? cfg.gain_active : cfg.gain_quiet;
    res.state_index  = nxt.gain_state;
  end

endmodule

// ===== verif/agc_step_checker.sv =====
// Checker for the AGC gain state stepper: watches the in_, out_ and cfg_ channels,
// predicts every result from its own copy of registers and state, and counts mismatches.
// Depends on agcgss_pkg.
module agc_step_checker
  import agcgss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    outstanding,
  output int                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                regs;
  logic [STATE_W-1:0]  gain_state;
  logic [TICK_W-1:0]   below_time;
  logic [TICK_W-1:0]   last_stamp;
  out_item_t           expected_gain_q[$];
  int                  fails = 0;

  assign fail_count = fails;

  function automatic out_item_t step_gain_fsm(in_item_t frame);
    logic [LEVEL_W-1:0] lo;
    logic [LEVEL_W-1:0] hi;
    logic [TICK_W-1:0]  dt;
    logic               changed;
    out_item_t          res;
    lo      = (gain_state == STATE_ACTIVE) ? regs.low_active : regs.low_quiet;
    hi      = (gain_state == STATE_ACTIVE) ? regs.high_active : regs.high_quiet;
    changed = 1'b0;
    if (frame.level < lo) begin
      if (last_stamp == '0) begin
        // a zero tick leaves the stamp unset
        last_stamp = frame.tick_now;
      end else begin
        dt = frame.tick_now - last_stamp;
        if (below_time > ({TICK_W{1'b1}} - dt))
          below_time = {TICK_W{1'b1}};
        else
          below_time = below_time + dt;
        if (below_time >= regs.hold_ticks) begin
          if (gain_state != STATE_LAST)
            gain_state = gain_state + 1'b1;
          below_time = '0;
          last_stamp = '0;
          changed    = 1'b1;
        end else begin
          last_stamp = frame.tick_now;
        end
      end
    end else if (frame.level > hi) begin
      // above range in the active state keeps the timers
      if (gain_state != STATE_ACTIVE) begin
        gain_state = STATE_ACTIVE;
        below_time = '0;
        last_stamp = '0;
        changed    = 1'b1;
      end
    end else begin
      below_time = '0;
      last_stamp = '0;
    end
    res.gain_changed = changed;
    res.gain_value   = (gain_state == STATE_ACTIVE) ? regs.gain_active : regs.gain_quiet;
    res.state_index  = gain_state;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      regs.gain_active = RST_GAIN_ACTIVE;
      regs.low_active  = RST_LOW_ACTIVE;
      regs.high_active = RST_HIGH_ACTIVE;
      regs.gain_quiet  = RST_GAIN_QUIET;
      regs.low_quiet   = RST_LOW_QUIET;
      regs.high_quiet  = RST_HIGH_QUIET;
      regs.hold_ticks  = RST_HOLD_TICKS;
      gain_state       = STATE_ACTIVE;
      below_time       = '0;
      last_stamp       = '0;
      expected_gain_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_ACTIVE: regs.gain_active = cfg_data[GAIN_W-1:0];
          REG_LOW_ACTIVE:  regs.low_active  = cfg_data[LEVEL_W-1:0];
          REG_HIGH_ACTIVE: regs.high_active = cfg_data[LEVEL_W-1:0];
          REG_GAIN_QUIET:  regs.gain_quiet  = cfg_data[GAIN_W-1:0];
          REG_LOW_QUIET:   regs.low_quiet   = cfg_data[LEVEL_W-1:0];
          REG_HIGH_QUIET:  regs.high_quiet  = cfg_data[LEVEL_W-1:0];
          REG_HOLD_TICKS:  regs.hold_ticks  = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      // results are checked before this edge's input is predicted
      if (out_valid && out_ready) begin
        if (expected_gain_q.size() == 0) begin
          $error("result transaction with no expectation: changed=%0d gain=%0d state=%0d",
                 out_data.gain_changed, out_data.gain_value, out_data.state_index);
          fails++;
        end else begin
          want = expected_gain_q.pop_front();
          if (out_data.gain_changed !== want.gain_changed) begin
            $error("gain_changed: expected %0d, actual %0d",
                   want.gain_changed, out_data.gain_changed);
            fails++;
          end
          if (out_data.gain_value !== want.gain_value) begin
            $error("gain_value: expected %0d, actual %0d",
                   want.gain_value, out_data.gain_value);
            fails++;
          end
          if (out_data.state_index !== want.state_index) begin
            $error("state_index: expected %0d, actual %0d",
                   want.state_index, out_data.state_index);
            fails++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_gain_q.push_back(step_gain_fsm(in_data));
    end
    outstanding <= expected_gain_q.size();
  end

endmodule

// ===== verif/tb_agc_gain_state_stepper_core.sv =====
// Testbench top for agc_gain_state_stepper_core: clock, reset, stimulus and verdict.
// Depends on agcgss_pkg, the block's RTL and agc_step_checker, which does all checking.
module tb_agc_gain_state_stepper_core;
  import agcgss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 92;
  localparam int HOG_CYCLES  = 120;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    outstanding;
  int                    fail_count;

  logic                  calm = 1'b0;    // no idling on either side
  logic                  hog_go = 1'b0;  // request for one long receiver hold-off
  int unsigned           src_pct = 10;
  cfg_t                  cur;            // register values as the block holds them

  agc_gain_state_stepper_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  agc_step_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_agc_gain_state_stepper_core failed");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin : sink
    int unsigned pct;
    int unsigned iter;
    logic        hog_done;
    out_ready <= 1'b0;
    pct       = 15;
    iter      = 0;
    hog_done  = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (iter % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       pct = 0;
          1:       pct = 15;
          default: pct = 50;
        endcase
      end
      iter++;
      if (hog_go && !hog_done) begin
        hog_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOG_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_frame(input logic [LEVEL_W-1:0] lvl, input logic [TICK_W-1:0] tck);
    if (!calm && $urandom_range(0, 99) < src_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {lvl, tck};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // every register, then a write to the unused index that must change nothing
  task automatic apply_regs(input logic [CFG_DATA_W-1:0] v [7]);
    write_reg(REG_GAIN_ACTIVE, v[0]);
    write_reg(REG_LOW_ACTIVE,  v[1]);
    write_reg(REG_HIGH_ACTIVE, v[2]);
    write_reg(REG_GAIN_QUIET,  v[3]);
    write_reg(REG_LOW_QUIET,   v[4]);
    write_reg(REG_HIGH_QUIET,  v[5]);
    write_reg(REG_HOLD_TICKS,  v[6]);
    write_reg(REG_UNUSED,      $urandom);
    cfg_valid <= 1'b0;
    cur.gain_active = v[0][GAIN_W-1:0];
    cur.low_active  = v[1][LEVEL_W-1:0];
    cur.high_active = v[2][LEVEL_W-1:0];
    cur.gain_quiet  = v[3][GAIN_W-1:0];
    cur.low_quiet   = v[4][LEVEL_W-1:0];
    cur.high_quiet  = v[5][LEVEL_W-1:0];
    cur.hold_ticks  = v[6][TICK_W-1:0];
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // levels aimed at the windows of both states
  function automatic logic [LEVEL_W-1:0] pick_level(int unsigned kind, cfg_t c);
    int v;
    case (kind)
      0, 1, 2: v = (c.low_active != 0) ? $urandom_range(0, c.low_active - 1) : 0;
      3, 4:    v = (c.low_quiet != 0) ? $urandom_range(0, c.low_quiet - 1) : 0;
      5:       v = int'(c.high_quiet) + $urandom_range(1, 3);
      6:       v = int'(c.high_active) + $urandom_range(1, 3);
      7: begin
        case ($urandom_range(0, 3))
          0:       v = c.low_active;
          1:       v = c.high_active;
          2:       v = c.low_quiet;
          default: v = c.high_quiet;
        endcase
      end
      8:       v = $urandom_range(0, 32767);
      default: v = $urandom_range(0, 1) ? 32767 : 0;
    endcase
    if (v > 32767)
      v = 32767;
    return LEVEL_W'(v);
  endfunction

  function automatic logic [TICK_W-1:0] next_tick(logic [TICK_W-1:0] t);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return $urandom;
      2:       return t - $urandom_range(1, 100);  // backwards: near-full wrapped delta
      3:       return 32'hFFFF_FFFF - $urandom_range(0, 50);
      default: return t + $urandom_range(0, 1500);
    endcase
  endfunction

  initial begin : stim
    logic [CFG_DATA_W-1:0] v [7];
    logic [TICK_W-1:0]     tick;
    int                    ph;
    int                    n;
    int                    k;
    int                    run;
    int unsigned           kind;
    int unsigned           la;
    int unsigned           lq;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    cur       = {RST_GAIN_ACTIVE, RST_LOW_ACTIVE, RST_HIGH_ACTIVE, RST_GAIN_QUIET,
                 RST_LOW_QUIET, RST_HIGH_QUIET, RST_HOLD_TICKS};
    tick      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults: unset stamp on a zero tick, step on, return on loud frame
    send_frame(15'd0, 32'd0);
    send_frame(15'd100, 32'd1000);
    send_frame(15'd32767, 32'd1200);
    send_frame(15'd349, 32'd3000);
    send_frame(15'd401, 32'd3100);
    send_frame(15'd350, 32'd3200);

    // zero hold, wide-open windows: immediate steps, repeat step in last state
    drain();
    v = '{32'hFFFF_FFFF, 32'd32767, 32'd32767, 32'h0000_0001, 32'd32767, 32'd32767, 32'd0};
    apply_regs(v);
    send_frame(15'd0, 32'd5);
    send_frame(15'd1, 32'd5);
    send_frame(15'd32766, 32'd7);
    send_frame(15'd32766, 32'd7);
    send_frame(15'd32767, 32'd9);
    send_frame(15'd2, 32'd0);

    // crossed window, max hold, tick wrap and accumulator saturation
    drain();
    v = '{32'h0000_8000, 32'd1000, 32'd10, 32'h0000_7FFF, 32'd0, 32'd0, 32'hFFFF_FFFF};
    apply_regs(v);
    send_frame(15'd20000, 32'd1);
    send_frame(15'd999, 32'hFFFF_FFF0);
    send_frame(15'd500, 32'h0000_0010);
    send_frame(15'd32767, 32'h0000_0020);
    send_frame(15'd0, 32'h0000_000F);
    send_frame(15'd1, 32'd5);
    send_frame(15'd0, 32'd0);

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        1: v = '{default: 32'd0};
        2: v = '{default: 32'hFFFF_FFFF};
        default: begin
          la   = $urandom_range(0, 3000);
          lq   = $urandom_range(0, 2000);
          v[0] = $urandom;
          v[1] = ($urandom & 32'hFFFF_8000) | la;
          v[2] = ($urandom & 32'hFFFF_8000) |
                 ($urandom_range(0, 3) == 0 ? $urandom_range(0, la)
                                            : la + $urandom_range(0, 25000));
          v[3] = $urandom;
          v[4] = ($urandom & 32'hFFFF_8000) | lq;
          v[5] = ($urandom & 32'hFFFF_8000) | (lq + $urandom_range(0, 3000));
          case ($urandom_range(0, 5))
            0:       v[6] = 32'd0;
            1:       v[6] = 32'hFFFF_FFFF;
            default: v[6] = $urandom_range(0, 4000);
          endcase
        end
      endcase
      apply_regs(v);
      if (ph == 0)
        hog_go <= 1'b1;
      if (ph == PHASES - 1)
        calm <= 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        kind = $urandom_range(0, 9);
        run  = $urandom_range(1, 8);
        case ($urandom_range(0, 2))
          0:       src_pct = 0;
          1:       src_pct = 10;
          default: src_pct = 40;
        endcase
        for (k = 0; k < run && n < PHASE_ITEMS; k++) begin
          tick = next_tick(tick);
          send_frame(pick_level(kind, cur), tick);
          n++;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("tb_agc_gain_state_stepper_core passed");
    else
      $display("tb_agc_gain_state_stepper_core failed");
    $finish;
  end

endmodule
